@@ design/assert_macros.svh @@
// assertion macros shared by the tenant monitor rtl
// expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

@@ design/tlfm_pkg.sv @@
// shared types and constants of the tenant latency fairness monitor
// no dependencies
package tlfm_pkg;

  localparam int NumTenants = 16;
  localparam int IdxW       = (NumTenants > 1) ? $clog2(NumTenants) : 1;
  localparam int NCntW      = $clog2(NumTenants + 1);

  localparam int ActW     = 2;
  localparam int TenantW  = 4;
  localparam int TimeW    = 48;
  localparam int BytesW   = 32;
  localparam int CntValW  = 32;
  localparam int AccW     = 64;
  localparam int MeanW    = 48;
  localparam int TputW    = 64;
  localparam int FairW    = 17;
  localparam int FracW    = 16;
  localparam int InvShift = 32;

  localparam int SumW  = AccW + NCntW;
  localparam int SqW   = 2 * AccW + NCntW;
  localparam int PW    = 2 * AccW + 2 * NCntW;
  localparam int DivW  = PW + FracW;
  localparam int StepW = $clog2(DivW + 1);

  localparam logic [FairW-1:0] JainOne = FairW'(1) << FracW;

  typedef enum logic [ActW-1:0] {
    ActRecord = 2'd0,
    ActRead   = 2'd1,
    ActFair   = 2'd2,
    ActClear  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    MulTsq = 2'd0,
    MulLsq = 2'd1,
    MulSs  = 2'd2,
    MulQn  = 2'd3
  } mul_op_e;

  typedef enum logic [1:0] {
    DivMean = 2'd0,
    DivTput = 2'd1,
    DivInv  = 2'd2,
    DivJain = 2'd3
  } div_op_e;

  typedef struct packed {
    logic    load_in;
    logic    rec_wr;
    logic    clr_store;
    logic    fair_clr;
    logic    idx_inc;
    logic    mul_start;
    mul_op_e mul_op;
    logic    div_start;
    div_op_e div_op;
    logic    t_acc;
    logic    t_sq_acc;
    logic    l_acc;
    logic    l_sq_acc;
    logic    num_cap;
    logic    jres_cap;
    logic    jsel;
    logic    mean_cap;
    logic    tput_cap;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic out_busy;
    logic last_idx;
  } sts_t;

endpackage

@@ design/tlfm_ctrl.sv @@
// sequencer of the tenant monitor: walks record, read, fairness and clear
// depends on tlfm_pkg and assert_macros.svh
`include "assert_macros.svh"

module tlfm_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [tlfm_pkg::ActW-1:0]  action_i,
  output logic                       in_ready_o,
  output tlfm_pkg::cmd_t             cmd_o,
  input  tlfm_pkg::sts_t             sts_i
);
  import tlfm_pkg::*;

  typedef enum logic [15:0] {
    StIdle  = 16'h0001,
    StRecWr = 16'h0002,
    StClr   = 16'h0004,
    StRdM   = 16'h0008,
    StRdMW  = 16'h0010,
    StRdTW  = 16'h0020,
    StFInit = 16'h0040,
    StFT    = 16'h0080,
    StFTW   = 16'h0100,
    StFLW   = 16'h0200,
    StFLW2  = 16'h0400,
    StJSs   = 16'h0800,
    StJSsW  = 16'h1000,
    StJQnW  = 16'h2000,
    StJDW   = 16'h4000,
    StEmit  = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   jsel_q, jsel_d;

  always_comb begin
    state_d    = state_q;
    jsel_d     = jsel_q;
    cmd_o      = '0;
    cmd_o.jsel = jsel_q;
    in_ready_o = (state_q == StIdle);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          case (act_e'(action_i))
            ActRecord: state_d = StRecWr;
            ActRead:   state_d = StRdM;
            ActFair:   state_d = StFInit;
            default:   state_d = StClr;
          endcase
        end
      end
      StRecWr: begin
        cmd_o.rec_wr = 1'b1;
        state_d      = StEmit;
      end
      StClr: begin
        cmd_o.clr_store = 1'b1;
        state_d         = StEmit;
      end
      StRdM: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DivMean;
        state_d         = StRdMW;
      end
      StRdMW: begin
        if (!sts_i.div_busy) begin
          cmd_o.mean_cap  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DivTput;
          state_d         = StRdTW;
        end
      end
      StRdTW: begin
        if (!sts_i.div_busy) begin
          cmd_o.tput_cap = 1'b1;
          state_d        = StEmit;
        end
      end
      StFInit: begin
        cmd_o.fair_clr = 1'b1;
        jsel_d         = 1'b0;
        state_d        = StFT;
      end
      StFT: begin
        cmd_o.t_acc     = 1'b1;
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = MulTsq;
        state_d         = StFTW;
      end
      StFTW: begin
        if (!sts_i.mul_busy) begin
          cmd_o.t_sq_acc  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DivInv;
          state_d         = StFLW;
        end
      end
      StFLW: begin
        if (!sts_i.div_busy) begin
          cmd_o.l_acc     = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = MulLsq;
          state_d         = StFLW2;
        end
      end
      StFLW2: begin
        if (!sts_i.mul_busy) begin
          cmd_o.l_sq_acc = 1'b1;
          if (sts_i.last_idx) begin
            state_d = StJSs;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = StFT;
          end
        end
      end
      StJSs: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_op    = MulSs;
        state_d         = StJSsW;
      end
      StJSsW: begin
        if (!sts_i.mul_busy) begin
          cmd_o.num_cap   = 1'b1;
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_op    = MulQn;
          state_d         = StJQnW;
        end
      end
      StJQnW: begin
        if (!sts_i.mul_busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DivJain;
          state_d         = StJDW;
        end
      end
      StJDW: begin
        if (!sts_i.div_busy) begin
          cmd_o.jres_cap = 1'b1;
          if (jsel_q) begin
            state_d = StEmit;
          end else begin
            jsel_d  = 1'b1;
            state_d = StJSs;
          end
        end
      end
      StEmit: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      jsel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      jsel_q  <= jsel_d;
    end
  end

  `ASSERT_NEVER(a_mul_start_busy, cmd_o.mul_start && sts_i.mul_busy, "mul started while busy")
  `ASSERT_NEVER(a_div_start_busy, cmd_o.div_start && sts_i.div_busy, "div started while busy")
  `ASSERT_CLK(a_out_load_free, cmd_o.out_load |-> !sts_i.out_busy, "result overwritten")

endmodule

@@ design/tlfm_dp.sv @@
// datapath of the tenant monitor: tenant store, shift-add multiplier,
// restoring divider, fairness accumulators and result register; uses tlfm_pkg
`include "assert_macros.svh"

module tlfm_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tlfm_pkg::ActW-1:0]    action_i,
  input  logic [tlfm_pkg::TenantW-1:0] tenant_i,
  input  logic [tlfm_pkg::TimeW-1:0]   arrival_time_i,
  input  logic [tlfm_pkg::TimeW-1:0]   finish_time_i,
  input  logic [tlfm_pkg::BytesW-1:0]  request_bytes_i,
  input  tlfm_pkg::cmd_t               cmd_i,
  output tlfm_pkg::sts_t               sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [tlfm_pkg::ActW-1:0]    answered_action_o,
  output logic [tlfm_pkg::CntValW-1:0] completed_count_o,
  output logic [tlfm_pkg::AccW-1:0]    latency_total_o,
  output logic [tlfm_pkg::AccW-1:0]    bytes_total_o,
  output logic [tlfm_pkg::MeanW-1:0]   mean_latency_o,
  output logic [tlfm_pkg::TputW-1:0]   mean_throughput_o,
  output logic [tlfm_pkg::FairW-1:0]   combined_fairness_o,
  output logic [tlfm_pkg::FairW-1:0]   throughput_fairness_o,
  output logic [tlfm_pkg::FairW-1:0]   latency_fairness_o
);
  import tlfm_pkg::*;

  // latched beat
  act_e               act_q;
  logic [TenantW-1:0] tenant_q;
  logic [TimeW-1:0]   arr_q, fin_q;
  logic [BytesW-1:0]  rbytes_q;
  logic [IdxW-1:0]    idx_q;
  logic               tvalid;

  // tenant store
  logic [CntValW-1:0] cnt_mem_q [NumTenants];
  logic [AccW-1:0]    lat_mem_q [NumTenants];
  logic [AccW-1:0]    byt_mem_q [NumTenants];
  logic [CntValW-1:0] c_rd;
  logic [AccW-1:0]    l_rd, b_rd;
  logic               bs_nz, lat_ok;

  logic [TimeW-1:0]   lat;
  logic [AccW:0]      lat_sum, byt_sum;
  logic [CntValW-1:0] cnt_new;
  logic [AccW-1:0]    lat_new, byt_new;

  // multiplier
  logic [PW-1:0]   mul_a_q, mul_p_q, mul_a_ld;
  logic [SumW-1:0] mul_b_q, mul_b_ld;
  logic            mul_busy_q;

  // divider
  logic [DivW-1:0]  div_n_q, div_n_ld;
  logic [PW-1:0]    div_r_q, div_d_q, div_d_ld;
  logic [StepW-1:0] div_cnt_q, div_cnt_ld;
  logic [PW:0]      div_t, div_diff;
  logic             div_ge;
  logic [AccW-1:0]  inv_v;

  // fairness accumulators
  logic [SumW-1:0]  t_sum_q, l_sum_q, sum_sel;
  logic [SqW-1:0]   t_sq_q, l_sq_q, sq_sel;
  logic [NCntW-1:0] t_n_q, l_n_q, n_sel;
  logic [DivW-1:0]  num_q;
  logic [FairW-1:0] tf_q, lf_q, jres, cf;
  logic [FairW:0]   f_sum;
  logic [MeanW-1:0] mean_q;
  logic [TputW-1:0] tput_q;

  logic out_valid_q;
  logic is_read, is_fair;

  assign tvalid = (32'(tenant_q) < 32'(NumTenants));
  assign c_rd   = cnt_mem_q[idx_q];
  assign l_rd   = lat_mem_q[idx_q];
  assign b_rd   = byt_mem_q[idx_q];
  assign bs_nz  = (b_rd != '0);
  assign lat_ok = (c_rd != '0) && (l_rd != '0);

  // saturating record update
  assign lat     = (fin_q > arr_q) ? (fin_q - arr_q) : '0;
  assign lat_sum = {1'b0, l_rd} + (AccW+1)'(lat);
  assign byt_sum = {1'b0, b_rd} + (AccW+1)'(rbytes_q);
  assign lat_new = lat_sum[AccW] ? '1 : lat_sum[AccW-1:0];
  assign byt_new = byt_sum[AccW] ? '1 : byt_sum[AccW-1:0];
  assign cnt_new = (&c_rd) ? c_rd : c_rd + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTenants; i++) begin
        cnt_mem_q[i] <= '0;
        lat_mem_q[i] <= '0;
        byt_mem_q[i] <= '0;
      end
    end else if (cmd_i.clr_store) begin
      for (int i = 0; i < NumTenants; i++) begin
        cnt_mem_q[i] <= '0;
        lat_mem_q[i] <= '0;
        byt_mem_q[i] <= '0;
      end
    end else if (cmd_i.rec_wr && tvalid) begin
      cnt_mem_q[idx_q] <= cnt_new;
      lat_mem_q[idx_q] <= lat_new;
      byt_mem_q[idx_q] <= byt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load_in) begin
      idx_q <= IdxW'(tenant_i);
    end else if (cmd_i.fair_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      act_q    <= act_e'(action_i);
      tenant_q <= tenant_i;
      arr_q    <= arrival_time_i;
      fin_q    <= finish_time_i;
      rbytes_q <= request_bytes_i;
    end
  end

  // shift-add multiplier, stops once the multiplier operand runs out of ones
  assign inv_v   = div_n_q[AccW-1:0];
  assign sum_sel = cmd_i.jsel ? l_sum_q : t_sum_q;
  assign sq_sel  = cmd_i.jsel ? l_sq_q : t_sq_q;
  assign n_sel   = cmd_i.jsel ? l_n_q : t_n_q;

  always_comb begin
    case (cmd_i.mul_op)
      MulTsq: begin
        mul_a_ld = PW'(b_rd);
        mul_b_ld = SumW'(b_rd);
      end
      MulLsq: begin
        mul_a_ld = PW'(inv_v);
        mul_b_ld = SumW'(inv_v);
      end
      MulSs: begin
        mul_a_ld = PW'(sum_sel);
        mul_b_ld = sum_sel;
      end
      default: begin
        mul_a_ld = PW'(sq_sel);
        mul_b_ld = SumW'(n_sel);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
    end else if (cmd_i.mul_start) begin
      mul_busy_q <= 1'b1;
    end else if (mul_busy_q && (mul_b_q == '0)) begin
      mul_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mul_a_q <= mul_a_ld;
      mul_b_q <= mul_b_ld;
      mul_p_q <= '0;
    end else if (mul_busy_q && (mul_b_q != '0)) begin
      if (mul_b_q[0]) begin
        mul_p_q <= mul_p_q + mul_a_q;
      end
      mul_a_q <= mul_a_q << 1;
      mul_b_q <= mul_b_q >> 1;
    end
  end

  // restoring divider, one quotient bit per cycle, dividend left-aligned
  always_comb begin
    case (cmd_i.div_op)
      DivMean: begin
        div_n_ld   = DivW'(l_rd) << (DivW - AccW);
        div_d_ld   = PW'(c_rd);
        div_cnt_ld = StepW'(AccW);
      end
      DivTput: begin
        div_n_ld   = DivW'({b_rd, {FracW{1'b0}}}) << (DivW - AccW - FracW);
        div_d_ld   = PW'(l_rd);
        div_cnt_ld = StepW'(AccW + FracW);
      end
      DivInv: begin
        div_n_ld   = DivW'({c_rd, {InvShift{1'b0}}}) << (DivW - CntValW - InvShift);
        div_d_ld   = PW'(l_rd);
        div_cnt_ld = StepW'(CntValW + InvShift);
      end
      default: begin
        div_n_ld   = num_q;
        div_d_ld   = mul_p_q;
        div_cnt_ld = StepW'(DivW);
      end
    endcase
  end

  assign div_t    = {div_r_q, div_n_q[DivW-1]};
  assign div_diff = div_t - {1'b0, div_d_q};
  assign div_ge   = (div_t >= {1'b0, div_d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= div_cnt_ld;
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_n_q <= div_n_ld;
      div_r_q <= '0;
      div_d_q <= div_d_ld;
    end else if (div_cnt_q != '0) begin
      div_n_q <= {div_n_q[DivW-2:0], div_ge};
      div_r_q <= div_ge ? div_diff[PW-1:0] : div_t[PW-1:0];
    end
  end

  // fairness and read results
  assign jres = (sum_sel == '0) ? '0 : div_n_q[FairW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.fair_clr) begin
      t_sum_q <= '0;
      t_sq_q  <= '0;
      t_n_q   <= '0;
      l_sum_q <= '0;
      l_sq_q  <= '0;
      l_n_q   <= '0;
    end else begin
      if (cmd_i.t_acc && bs_nz) begin
        t_sum_q <= t_sum_q + SumW'(b_rd);
        t_n_q   <= t_n_q + 1'b1;
      end
      if (cmd_i.t_sq_acc && bs_nz) begin
        t_sq_q <= t_sq_q + SqW'(mul_p_q);
      end
      if (cmd_i.l_acc && lat_ok) begin
        l_sum_q <= l_sum_q + SumW'(inv_v);
        l_n_q   <= l_n_q + 1'b1;
      end
      if (cmd_i.l_sq_acc && lat_ok) begin
        l_sq_q <= l_sq_q + SqW'(mul_p_q);
      end
    end
    if (cmd_i.num_cap) begin
      num_q <= DivW'(mul_p_q) << FracW;
    end
    if (cmd_i.jres_cap) begin
      if (cmd_i.jsel) begin
        lf_q <= jres;
      end else begin
        tf_q <= jres;
      end
    end
    if (cmd_i.mean_cap) begin
      if (c_rd == '0) begin
        mean_q <= '0;
      end else begin
        mean_q <= (|div_n_q[AccW-1:MeanW]) ? '1 : div_n_q[MeanW-1:0];
      end
    end
    if (cmd_i.tput_cap) begin
      if (l_rd == '0) begin
        tput_q <= '0;
      end else begin
        tput_q <= (|div_n_q[AccW+FracW-1:AccW]) ? '1 : div_n_q[TputW-1:0];
      end
    end
  end

  assign f_sum = {1'b0, tf_q} + {1'b0, lf_q};
  assign cf    = (tf_q == '0) ? lf_q : ((lf_q == '0) ? tf_q : f_sum[FairW:1]);

  // result register
  assign is_read = (act_q == ActRead) && tvalid;
  assign is_fair = (act_q == ActFair);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      answered_action_o     <= act_q;
      completed_count_o     <= is_read ? c_rd : '0;
      latency_total_o       <= is_read ? l_rd : '0;
      bytes_total_o         <= is_read ? b_rd : '0;
      mean_latency_o        <= is_read ? mean_q : '0;
      mean_throughput_o     <= is_read ? tput_q : '0;
      combined_fairness_o   <= is_fair ? cf : '0;
      throughput_fairness_o <= is_fair ? tf_q : '0;
      latency_fairness_o    <= is_fair ? lf_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.mul_busy  = mul_busy_q;
  assign sts_o.div_busy  = (div_cnt_q != '0);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign sts_o.last_idx  = (32'(idx_q) == 32'(NumTenants - 1));

  `ASSERT_CLK(a_rec_count_nz, cmd_i.rec_wr && tvalid |=> cnt_mem_q[$past(idx_q)] != '0, "count zero after record")
  `ASSERT_CLK(a_jain_bound, cmd_i.jres_cap && !cmd_i.jsel |=> tf_q <= JainOne, "index above one")

endmodule

@@ design/tenant_latency_fairness_monitor.sv @@
// top level of the tenant latency fairness monitor
// instantiates tlfm_ctrl and tlfm_dp; uses tlfm_pkg
//
//   channel | signals                        | direction
//   --------+--------------------------------+----------
//   in      | in_valid_i / in_ready_o        | action, tenant, times, request bytes in
//   out     | out_valid_o / out_ready_i      | one result beat per input beat
//
// record: accept, saturating write, result load
// read: two passes of the one-bit-per-cycle divider (64 and 80 steps)
// fairness: per tenant two shift-add squarings and a 64-step divide,
//   then per index two multiplies and a 154-step divide
// clear: accept, store wipe, result load; reset zeroes the tenant store at once
// no beat is taken until the previous result is loaded; a stalled output holds the block
module tenant_latency_fairness_monitor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tlfm_pkg::ActW-1:0]    action_i,
  input  logic [tlfm_pkg::TenantW-1:0] tenant_i,
  input  logic [tlfm_pkg::TimeW-1:0]   arrival_time_i,
  input  logic [tlfm_pkg::TimeW-1:0]   finish_time_i,
  input  logic [tlfm_pkg::BytesW-1:0]  request_bytes_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tlfm_pkg::ActW-1:0]    answered_action_o,
  output logic [tlfm_pkg::CntValW-1:0] completed_count_o,
  output logic [tlfm_pkg::AccW-1:0]    latency_total_o,
  output logic [tlfm_pkg::AccW-1:0]    bytes_total_o,
  output logic [tlfm_pkg::MeanW-1:0]   mean_latency_o,
  output logic [tlfm_pkg::TputW-1:0]   mean_throughput_o,
  output logic [tlfm_pkg::FairW-1:0]   combined_fairness_o,
  output logic [tlfm_pkg::FairW-1:0]   throughput_fairness_o,
  output logic [tlfm_pkg::FairW-1:0]   latency_fairness_o
);
  import tlfm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tlfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tlfm_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .action_i              (action_i),
    .tenant_i              (tenant_i),
    .arrival_time_i        (arrival_time_i),
    .finish_time_i         (finish_time_i),
    .request_bytes_i       (request_bytes_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .out_ready_i           (out_ready_i),
    .out_valid_o           (out_valid_o),
    .answered_action_o     (answered_action_o),
    .completed_count_o     (completed_count_o),
    .latency_total_o       (latency_total_o),
    .bytes_total_o         (bytes_total_o),
    .mean_latency_o        (mean_latency_o),
    .mean_throughput_o     (mean_throughput_o),
    .combined_fairness_o   (combined_fairness_o),
    .throughput_fairness_o (throughput_fairness_o),
    .latency_fairness_o    (latency_fairness_o)
  );

endmodule

@@ tb/tenant_latency_fairness_monitor_tb.sv @@
// testbench of tenant_latency_fairness_monitor: a directed table, then random beats
// with bursty idling on both channels, all checked against a predictor of the
// tenant store and of the fairness math; needs tlfm_pkg and the rtl only
`timescale 1ns / 1ps

module tenant_latency_fairness_monitor_tb;
  import tlfm_pkg::*;

  typedef struct {
    act_e            act;
    logic [3:0]      tenant;
    logic [47:0]     arr;
    logic [47:0]     fin;
    logic [31:0]     nbytes;
    bit              typed;
  } beat_t;

  typedef struct {
    logic [1:0]      act;
    logic [31:0]     cnt;
    logic [63:0]     lat;
    logic [63:0]     byt;
    logic [47:0]     mean;
    logic [63:0]     tput;
    logic [16:0]     comb;
    logic [16:0]     tfair;
    logic [16:0]     lfair;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [ActW-1:0] action_i = '0;
  logic [TenantW-1:0] tenant_i = '0;
  logic [TimeW-1:0] arrival_time_i = '0;
  logic [TimeW-1:0] finish_time_i = '0;
  logic [BytesW-1:0] request_bytes_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ActW-1:0] answered_action_o;
  logic [CntValW-1:0] completed_count_o;
  logic [AccW-1:0] latency_total_o;
  logic [AccW-1:0] bytes_total_o;
  logic [MeanW-1:0] mean_latency_o;
  logic [TputW-1:0] mean_throughput_o;
  logic [FairW-1:0] combined_fairness_o;
  logic [FairW-1:0] throughput_fairness_o;
  logic [FairW-1:0] latency_fairness_o;

  tenant_latency_fairness_monitor dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [31:0] tenant_cnt [16];
  logic [63:0] tenant_lat [16];
  logic [63:0] tenant_byt [16];
  stats_t pending_stats[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;

  function automatic logic [16:0] fair_index_q16(input logic [63:0] v [16], input int n);
    logic [191:0] s, q, x, num, den;
    s = '0;
    q = '0;
    for (int i = 0; i < n; i++) begin
      x = 192'(v[i]);
      s = s + x;
      q = q + x * x;
    end
    if (n == 0 || q == 0) return '0;
    num = (s * s) << 16;
    den = q * 192'(n);
    return 17'(num / den);
  endfunction

  function automatic stats_t predict_stats(input beat_t b);
    stats_t r;
    logic [63:0] lat, sum;
    logic [127:0] tq;
    logic [63:0] tv [16];
    logic [63:0] lv [16];
    int nt, nl;
    r = '{act: b.act, default: '0};
    nt = 0;
    nl = 0;
    case (b.act)
      ActRecord: begin
        lat = (b.fin > b.arr) ? 64'(b.fin - b.arr) : 64'd0;
        if (tenant_cnt[b.tenant] != '1) tenant_cnt[b.tenant]++;
        sum = tenant_lat[b.tenant] + lat;
        tenant_lat[b.tenant] = (sum < lat) ? '1 : sum;
        sum = tenant_byt[b.tenant] + 64'(b.nbytes);
        tenant_byt[b.tenant] = (sum < 64'(b.nbytes)) ? '1 : sum;
      end
      ActRead: begin
        r.cnt = tenant_cnt[b.tenant];
        r.lat = tenant_lat[b.tenant];
        r.byt = tenant_byt[b.tenant];
        if (r.cnt != 0) begin
          sum = r.lat / r.cnt;
          r.mean = (sum > 64'hFFFF_FFFF_FFFF) ? '1 : 48'(sum);
        end
        if (r.lat != 0) begin
          tq = {r.byt, 16'd0} / {64'd0, r.lat};
          r.tput = (tq[127:64] != 0) ? '1 : tq[63:0];
        end
      end
      ActFair: begin
        for (int i = 0; i < 16; i++) begin
          if (tenant_byt[i] != 0) tv[nt++] = tenant_byt[i];
          if (tenant_cnt[i] != 0 && tenant_lat[i] != 0)
            lv[nl++] = {tenant_cnt[i], 32'd0} / tenant_lat[i];
        end
        r.tfair = fair_index_q16(tv, nt);
        r.lfair = fair_index_q16(lv, nl);
        if (r.tfair == 0) r.comb = r.lfair;
        else if (r.lfair == 0) r.comb = r.tfair;
        else r.comb = 17'((18'(r.tfair) + 18'(r.lfair)) >> 1);
      end
      default: begin
        for (int i = 0; i < 16; i++) begin
          tenant_cnt[i] = '0;
          tenant_lat[i] = '0;
          tenant_byt[i] = '0;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_beat(input beat_t b);
    stats_t e;
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(negedge clk_i);
    action_i = b.act;
    tenant_i = b.tenant;
    arrival_time_i = b.arr;
    finish_time_i = b.fin;
    request_bytes_i = b.nbytes;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    e = predict_stats(b);
    if (b.typed) e = '{act: b.act, default: '0};
    pending_stats.insert(pending_stats.size(), e);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // output stall bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    stats_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result beat, action %0d", $time, answered_action_o);
        errors++;
      end else begin
        e = pending_stats.pop_front();
        if (answered_action_o !== e.act || completed_count_o !== e.cnt ||
            latency_total_o !== e.lat || bytes_total_o !== e.byt ||
            mean_latency_o !== e.mean || mean_throughput_o !== e.tput ||
            combined_fairness_o !== e.comb || throughput_fairness_o !== e.tfair ||
            latency_fairness_o !== e.lfair) begin
          $display("%0t: expected act %0d cnt %0d lat %0d byt %0d mean %0d tput %0d",
                   $time, e.act, e.cnt, e.lat, e.byt, e.mean, e.tput);
          $display("%0t:   fair c/t/l %0d %0d %0d", $time, e.comb, e.tfair, e.lfair);
          $display("%0t: actual act %0d cnt %0d lat %0d byt %0d mean %0d tput %0d",
                   $time, answered_action_o, completed_count_o, latency_total_o,
                   bytes_total_o, mean_latency_o, mean_throughput_o);
          $display("%0t:   fair c/t/l %0d %0d %0d", $time, combined_fairness_o,
                   throughput_fairness_o, latency_fairness_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 4000000) begin
      $display("tenant_latency_fairness_monitor: mismatch");
      $finish;
    end
  end

  function automatic beat_t random_beat();
    beat_t b;
    int sel;
    logic [47:0] base;
    sel = $urandom_range(0, 99);
    b.typed = 0;
    b.tenant = 4'($urandom_range(0, 15));
    b.arr = 48'({$urandom, $urandom});
    b.fin = 48'({$urandom, $urandom});
    b.nbytes = $urandom;
    if (sel < 70) begin
      b.act = ActRecord;
      base = 48'({$urandom, $urandom});
      case ($urandom_range(0, 9))
        0, 1: ;
        2: b.nbytes = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
        3: b.fin = b.arr;
        default: begin
          b.arr = base;
          b.fin = base + 48'($urandom_range(0, 5000));
          b.nbytes = $urandom_range(0, 1 << 20);
        end
      endcase
    end else if (sel < 94) b.act = ActRead;
    else if (sel < 99) b.act = ActFair;
    else b.act = ActClear;
    return b;
  endfunction

  beat_t directed [] = '{
    '{ActRead,   4'd0,  48'd0,    48'd0,    32'd0,         1},
    '{ActFair,   4'd0,  48'd0,    48'd0,    32'd0,         1},
    '{ActRecord, 4'd0,  48'd100,  48'd150,  32'd1000,      1},
    '{ActRecord, 4'd15, 48'd0,    '1,       32'hFFFF_FFFF, 1},
    '{ActRecord, 4'd3,  '1,       48'd0,    32'd0,         1},
    '{ActRead,   4'd0,  48'd0,    48'd0,    32'd0,         0},
    '{ActRead,   4'd15, '1,       '1,       '1,            0},
    '{ActRead,   4'd3,  48'd0,    48'd0,    32'd0,         0},
    '{ActFair,   4'd0,  48'd0,    48'd0,    32'd0,         0},
    '{ActRecord, 4'd5,  48'd0,    48'h8000_0000_0000, 32'd5, 1},
    '{ActFair,   4'd9,  '1,       '1,       '1,            0},
    '{ActRead,   4'd5,  48'd0,    48'd0,    32'd0,         0},
    '{ActRecord, 4'd15, 48'd7,    48'd8,    32'd1,         1},
    '{ActRead,   4'd15, 48'd0,    48'd0,    32'd0,         0},
    '{ActClear,  4'd0,  48'd0,    48'd0,    32'd0,         1},
    '{ActRead,   4'd15, 48'd0,    48'd0,    32'd0,         1},
    '{ActFair,   4'd0,  48'd0,    48'd0,    32'd0,         1}
  };

  initial begin
    for (int i = 0; i < 16; i++) begin
      tenant_cnt[i] = '0;
      tenant_lat[i] = '0;
      tenant_byt[i] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_beat(directed[i]);
    for (int i = 0; i < 1500; i++) begin
      if (i == 700) wait (pending_stats.size() == 0);
      if (i == 1300) calm = 1;
      send_beat(random_beat());
    end
    wait (pending_stats.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("tenant_latency_fairness_monitor: match");
    else $display("tenant_latency_fairness_monitor: mismatch");
    $finish;
  end
endmodule
